/* rtl/chtab_pkg.sv */
// Package for the chained hash table: field widths, operation and status codes,
// default sizes and the controller state type. No dependencies.
`timescale 1ns / 1ps

package chtab_pkg;

    localparam int CHT_BUCKETS     = 16;
    localparam int CHT_POOL_NODES  = 64;
    localparam int CHT_VALUE_WIDTH = 32;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 31;
    localparam int ST_W    = 2;
    localparam int FOUND_W = 32;

    // Steps of the bucket remainder: a reciprocal multiply, then a multiply and
    // subtract.
    localparam int MOD_ITER   = 2;
    localparam int MOD_ITER_W = $clog2(MOD_ITER);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_NODE_CHK,
        S_TAIL_FIX,
        S_RESULT
    } t_state;

endpackage

/* rtl/chained_hash_table.sv */
// Hash table with separate chaining: one inline head slot per bucket and a
// never-reclaimed pool of chain nodes, both held in synchronous memories.
// Depends on chtab_pkg.
//
// Usage: the input stream carries one operation per beat (tuser = operation:
// insert, search or delete; tdata = key and value). The output stream returns
// exactly one beat per operation (tuser = status, tdata = found value).
// After reset the block runs a clearing pass over the head memory, one bucket
// per cycle, with s_axis_tready low. It then handles one operation at a time:
// it takes the beat, reduces the key modulo BUCKETS (a reciprocal multiply,
// then a multiply and subtract), reads the head memory, checks the head slot,
// visits each chain node in turn through the node memory read port, links a
// newly appended node behind an existing chain, and hands the result to the
// output register; the next beat is taken only after that.
// Each bucket keeps a tail pointer, so an insert never walks the chain. A
// stalled receiver holds the result in the output register; the next operation
// is taken and processed meanwhile and waits at its end until the register frees.
`timescale 1ns / 1ps

module chained_hash_table #(
    parameter int BUCKETS     = chtab_pkg::CHT_BUCKETS,
    parameter int POOL_NODES  = chtab_pkg::CHT_POOL_NODES,
    parameter int VALUE_WIDTH = chtab_pkg::CHT_VALUE_WIDTH
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    // Fields from bit 0 up: key (31 bits), value (VALUE_WIDTH bits), zero fill.
    input  logic [((chtab_pkg::KEY_W + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Fields from bit 0 up: operation (2 bits).
    input  logic [chtab_pkg::OP_W-1:0]                     s_axis_tuser,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    // Fields from bit 0 up: found_value (32 bits).
    output logic [chtab_pkg::FOUND_W-1:0]                  m_axis_tdata,
    // Fields from bit 0 up: status (2 bits).
    output logic [chtab_pkg::ST_W-1:0]                     m_axis_tuser
);

    import chtab_pkg::*;

    localparam int BIDX_W      = $clog2(BUCKETS);
    localparam int LINK_W      = $clog2(POOL_NODES + 1);
    localparam int NIDX_W      = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int RECIP_SHIFT = KEY_W + BIDX_W;
    localparam int PROD_W      = 2 * KEY_W + 1;

    // Rounded-up reciprocal of BUCKETS; with this shift the quotient is exact for
    // every key of KEY_W bits.
    localparam logic [KEY_W:0] RECIP = (KEY_W + 1)'(((64'd1 << RECIP_SHIFT)
        + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    localparam logic [LINK_W-1:0] NO_NODE = LINK_W'(POOL_NODES);

    typedef struct packed {
        logic                   used;
        logic [KEY_W-1:0]       key;
        logic [VALUE_WIDTH-1:0] value;
        logic [LINK_W-1:0]      link;
        logic [NIDX_W-1:0]      tail;
    } t_head_ent;

    typedef struct packed {
        logic                   used;
        logic [KEY_W-1:0]       key;
        logic [VALUE_WIDTH-1:0] value;
        logic [LINK_W-1:0]      link;
    } t_node_ent;

    t_head_ent head_mem [BUCKETS];
    t_node_ent node_mem [POOL_NODES];

    t_state                 r_state, n_state;
    logic [OP_W-1:0]        r_op, n_op;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic [BIDX_W-1:0]      r_rem, n_rem;
    logic [MOD_ITER_W-1:0]  r_iter, n_iter;
    logic [BIDX_W-1:0]      r_clr, n_clr;
    logic [NIDX_W-1:0]      r_cur, n_cur;
    logic [LINK_W-1:0]      r_fresh, n_fresh;
    logic [LINK_W-1:0]      r_next_free, n_next_free;
    logic [ST_W-1:0]        r_res_status, n_res_status;
    logic [FOUND_W-1:0]     r_res_found, n_res_found;
    logic                   r_out_valid, n_out_valid;
    logic [ST_W-1:0]        r_out_status, n_out_status;
    logic [FOUND_W-1:0]     r_out_found, n_out_found;
    t_head_ent              r_head_q;
    t_node_ent              r_node_q;

    logic                   head_we, head_re;
    logic [BIDX_W-1:0]      head_waddr, head_raddr;
    t_head_ent              head_wdata;
    logic                   node_we, node_re;
    logic [NIDX_W-1:0]      node_waddr, node_raddr;
    t_node_ent              node_wdata;

    logic                   in_accept;
    logic                   out_free;
    logic                   hit_head, hit_node;
    logic                   pool_full;
    logic [KEY_W-1:0]       quot;
    logic [BIDX_W-1:0]      rem_calc;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign hit_head  = r_head_q.used && (r_head_q.key == r_key);
    assign hit_node  = r_node_q.used && (r_node_q.key == r_key);
    assign pool_full = (r_next_free >= NO_NODE);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_found;
    assign m_axis_tuser  = r_out_status;

    // The remainder is below BUCKETS, so only the low bits of the difference
    // between the key and quotient times BUCKETS are needed.
    assign quot     = KEY_W'(r_prod >> RECIP_SHIFT);
    assign rem_calc = r_key[BIDX_W-1:0] - BIDX_W'(quot * KEY_W'(BUCKETS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == BIDX_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (r_iter == MOD_ITER_W'(MOD_ITER - 1)) begin
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                n_state = S_HEAD_CHK;
            end
            S_HEAD_CHK: begin
                n_state = S_RESULT;
                unique case (r_op)
                    OP_INSERT: begin
                        if (r_head_q.used && !pool_full && r_head_q.link != NO_NODE) begin
                            n_state = S_TAIL_FIX;
                        end
                    end
                    OP_SEARCH, OP_DELETE: begin
                        if (!hit_head && r_head_q.link != NO_NODE) begin
                            n_state = S_NODE_CHK;
                        end
                    end
                    default: n_state = S_RESULT;
                endcase
            end
            S_NODE_CHK: begin
                if (hit_node || r_node_q.link == NO_NODE) begin
                    n_state = S_RESULT;
                end
            end
            S_TAIL_FIX: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Operations run one at a time and every write of an operation lands before
    // the next one reads, so the memories need no forwarding path.
    always_comb begin
        head_we      = 1'b0;
        head_re      = 1'b0;
        head_waddr   = r_rem;
        head_raddr   = r_rem;
        head_wdata   = r_head_q;
        node_we      = 1'b0;
        node_re      = 1'b0;
        node_waddr   = r_cur;
        node_raddr   = r_cur;
        node_wdata   = r_node_q;
        n_op         = r_op;
        n_key        = r_key;
        n_value      = r_value;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_iter       = r_iter;
        n_clr        = r_clr;
        n_cur        = r_cur;
        n_fresh      = r_fresh;
        n_next_free  = r_next_free;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;

        unique case (r_state)
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = '{used: 1'b0, key: '0, value: '0, link: NO_NODE, tail: '0};
                n_clr      = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_op    = s_axis_tuser;
                    n_key   = s_axis_tdata[KEY_W-1:0];
                    n_value = s_axis_tdata[KEY_W +: VALUE_WIDTH];
                    n_rem   = '0;
                    n_iter  = '0;
                end
            end
            S_MOD: begin
                // The first step forms the scaled quotient, the second the remainder.
                if (r_iter == '0) begin
                    n_prod = PROD_W'(r_key) * PROD_W'(RECIP);
                end else begin
                    n_rem = rem_calc;
                end
                n_iter = r_iter + 1'b1;
            end
            S_HEAD_RD: begin
                head_re = 1'b1;
            end
            S_HEAD_CHK: begin
                n_res_status = ST_MISS;
                n_res_found  = '0;
                unique case (r_op)
                    OP_INSERT: begin
                        if (!r_head_q.used) begin
                            // A free head slot is reused and keeps its chain.
                            head_we          = 1'b1;
                            head_wdata.used  = 1'b1;
                            head_wdata.key   = r_key;
                            head_wdata.value = r_value;
                            n_res_status     = ST_OK;
                        end else if (pool_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            node_we     = 1'b1;
                            node_waddr  = r_next_free[NIDX_W-1:0];
                            node_wdata  = '{used: 1'b1, key: r_key, value: r_value,
                                            link: NO_NODE};
                            n_next_free = r_next_free + 1'b1;
                            n_fresh     = r_next_free;
                            head_we     = 1'b1;
                            head_wdata.tail = r_next_free[NIDX_W-1:0];
                            if (r_head_q.link == NO_NODE) begin
                                head_wdata.link = r_next_free;
                            end else begin
                                // Fetch the old tail so its link can be rewritten.
                                node_re    = 1'b1;
                                node_raddr = r_head_q.tail;
                                n_cur      = r_head_q.tail;
                            end
                            n_res_status = ST_OK;
                        end
                    end
                    OP_SEARCH, OP_DELETE: begin
                        if (hit_head) begin
                            n_res_status = ST_OK;
                            if (r_op == OP_SEARCH) begin
                                n_res_found = FOUND_W'(r_head_q.value);
                            end else begin
                                head_we         = 1'b1;
                                head_wdata.used = 1'b0;
                            end
                        end else if (r_head_q.link != NO_NODE) begin
                            node_re    = 1'b1;
                            node_raddr = r_head_q.link[NIDX_W-1:0];
                            n_cur      = r_head_q.link[NIDX_W-1:0];
                        end
                    end
                    default: n_res_status = ST_MISS;
                endcase
            end
            S_NODE_CHK: begin
                if (hit_node) begin
                    n_res_status = ST_OK;
                    if (r_op == OP_SEARCH) begin
                        n_res_found = FOUND_W'(r_node_q.value);
                    end else begin
                        node_we         = 1'b1;
                        node_wdata.used = 1'b0;
                    end
                end else if (r_node_q.link != NO_NODE) begin
                    node_re    = 1'b1;
                    node_raddr = r_node_q.link[NIDX_W-1:0];
                    n_cur      = r_node_q.link[NIDX_W-1:0];
                end
            end
            S_TAIL_FIX: begin
                node_we         = 1'b1;
                node_wdata.link = r_fresh;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_found  = r_res_found;
                end
            end
            default: n_clr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re) begin
            r_head_q <= head_mem[head_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            r_node_q <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_value      <= n_value;
        r_prod       <= n_prod;
        r_rem        <= n_rem;
        r_iter       <= n_iter;
        r_cur        <= n_cur;
        r_fresh      <= n_fresh;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
    end

endmodule

/* tb/chained_hash_table_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for chained_hash_table: directed and random insert, search and delete
// beats, with results checked against a behavioral copy of the table in a scoreboard class.
// Depends on chtab_pkg and the chained_hash_table RTL.

module chained_hash_table_test;
    import chtab_pkg::*;

    localparam int BUCKETS      = CHT_BUCKETS;
    localparam int POOL         = CHT_POOL_NODES;
    localparam int VW           = CHT_VALUE_WIDTH;
    localparam int TDATA_W      = ((KEY_W + VW + 7) / 8) * 8;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 880;
    localparam int LIMIT_CYCLES = 600000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOT_BUCKET   = 5;
    localparam int KEY_SET      = 48;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [FOUND_W-1:0] found;
    } t_table_result;

    class chain_table_scoreboard;
        bit               head_used  [BUCKETS];
        logic [KEY_W-1:0] head_key   [BUCKETS];
        logic [VW-1:0]    head_value [BUCKETS];
        int               head_link  [BUCKETS];
        bit               node_used  [POOL];
        logic [KEY_W-1:0] node_key   [POOL];
        logic [VW-1:0]    node_value [POOL];
        int               node_link  [POOL];
        int               next_free;
        t_table_result    expected_results [$];
        int errors;
        int n_checked;
        int n_found;
        int n_miss;
        int n_full;

        function new();
            for (int i = 0; i < BUCKETS; i++) begin
                head_used[i]  = 1'b0;
                head_key[i]   = '0;
                head_value[i] = '0;
                head_link[i]  = POOL;
            end
            for (int i = 0; i < POOL; i++) begin
                node_used[i]  = 1'b0;
                node_key[i]   = '0;
                node_value[i] = '0;
                node_link[i]  = 0;
            end
            next_free = 0;
            errors    = 0;
            n_checked = 0;
            n_found   = 0;
            n_miss    = 0;
            n_full    = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Head slot first, then the chain in link order; tombstones are skipped.
        function bit find_first(int b, logic [KEY_W-1:0] k, output bit in_head,
                                output int where);
            int n;
            in_head = 1'b0;
            where   = 0;
            if (head_used[b] && head_key[b] == k) begin
                in_head = 1'b1;
                return 1'b1;
            end
            n = head_link[b];
            while (n < POOL) begin
                if (node_used[n] && node_key[n] == k) begin
                    where = n;
                    return 1'b1;
                end
                n = node_link[n];
            end
            return 1'b0;
        endfunction

        function logic [ST_W-1:0] insert_entry(int b, logic [KEY_W-1:0] k, logic [VW-1:0] v);
            int n;
            int fresh;
            if (!head_used[b]) begin
                // A free or tombstoned head slot is refilled; its chain stays attached.
                head_used[b]  = 1'b1;
                head_key[b]   = k;
                head_value[b] = v;
                return ST_OK;
            end
            if (next_free >= POOL)
                return ST_FULL;
            fresh = next_free;
            next_free++;
            node_used[fresh]  = 1'b1;
            node_key[fresh]   = k;
            node_value[fresh] = v;
            node_link[fresh]  = POOL;
            n = head_link[b];
            if (n >= POOL) begin
                head_link[b] = fresh;
                return ST_OK;
            end
            while (node_link[n] < POOL)
                n = node_link[n];
            node_link[n] = fresh;
            return ST_OK;
        endfunction

        function void note_operation(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic [VW-1:0] v);
            t_table_result res;
            int  b;
            bit  in_head;
            int  where;
            b          = int'(k % BUCKETS);
            res.status = ST_MISS;
            res.found  = '0;
            case (op)
                OP_INSERT: begin
                    res.status = insert_entry(b, k, v);
                end
                OP_SEARCH: begin
                    if (find_first(b, k, in_head, where)) begin
                        res.status = ST_OK;
                        res.found  = in_head ? head_value[b] : node_value[where];
                    end
                end
                OP_DELETE: begin
                    if (find_first(b, k, in_head, where)) begin
                        res.status = ST_OK;
                        if (in_head)
                            head_used[b] = 1'b0;
                        else
                            node_used[where] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            if (res.status == ST_FULL)
                n_full++;
            else if (res.status == ST_MISS)
                n_miss++;
            else if (op == OP_SEARCH)
                n_found++;
            expected_results.push_back(res);
        endfunction

        task report(string what, logic [FOUND_W-1:0] got, logic [FOUND_W-1:0] want);
            errors++;
            if (errors <= 30)
                $display("MISMATCH %s at result %0d: got %0h, expected %0h",
                         what, n_checked, got, want);
        endtask

        task check_result(logic [ST_W-1:0] status, logic [FOUND_W-1:0] found);
            t_table_result want;
            if (expected_results.size() == 0) begin
                report("unexpected output beat", found, '0);
            end else begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report("status", FOUND_W'(status), FOUND_W'(want.status));
                if (found !== want.found)
                    report("found_value", found, want.found);
            end
            n_checked++;
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic [OP_W-1:0]    s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [FOUND_W-1:0] m_axis_tdata;
    logic [ST_W-1:0]    m_axis_tuser;

    chain_table_scoreboard sb;
    logic [KEY_W-1:0] key_set [KEY_SET];
    int  n_sent;
    int  cycles;
    bit  tx_quiet;
    bit  rx_quiet;
    bit  rx_holding;
    bit  long_hold_done;

    chained_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 75)
            k = key_set[$urandom_range(0, KEY_SET - 1)];
        else if (r < 80)
            k = ($urandom_range(0, 1) == 0) ? '0 : KEY_MAX;
        else
            k = KEY_W'($urandom);
        return k;
    endfunction

    function automatic logic [VW-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return VW'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return OP_INSERT;
        else if (r < 65)
            return OP_SEARCH;
        else if (r < 93)
            return OP_DELETE;
        return OP_UNUSED;
    endfunction

    // Called at a falling edge; returns at a falling edge after the beat is taken.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                           input logic [VW-1:0] v);
        int gap;
        s_axis_tuser  = op;
        s_axis_tdata  = {{(TDATA_W - KEY_W - VW){1'b0}}, v, k};
        s_axis_tvalid = 1'b1;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        sb.note_operation(op, k, v);
        n_sent++;
        @(negedge i_clk);
        gap = (tx_quiet || rx_holding) ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Receiver: random ready pattern plus one long hold-off so the block backs up.
    initial begin : receiver
        int stretch;
        int held;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && sb.n_checked >= 150) begin
                rx_holding    = 1'b1;
                m_axis_tready = 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(negedge i_clk);
                rx_holding     = 1'b0;
                long_hold_done = 1'b1;
            end
            if ($urandom_range(0, 19) == 0)
                rx_quiet = !rx_quiet;
            stretch       = rx_quiet ? 40 : $urandom_range(1, 12);
            m_axis_tready = 1'b1;
            repeat (stretch) @(negedge i_clk);
            stretch = rx_quiet ? 0 : pick_gap();
            if (stretch > 0) begin
                m_axis_tready = 1'b0;
                repeat (stretch) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0] k;
        sb             = new();
        n_sent         = 0;
        tx_quiet       = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_INSERT;

        // Keys with random upper bits: two per bucket, plus a crowd in one bucket
        // so that at least one chain grows long.
        for (int i = 0; i < KEY_SET; i++) begin
            k = KEY_W'($urandom);
            k[3:0] = (i < 32) ? 4'(i % BUCKETS) : 4'(HOT_BUCKET);
            key_set[i] = k;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: empty table, extremes, chains, duplicates, tombstones,
        // head reuse with a live chain, and the unused operation code.
        send_op(OP_SEARCH, '0, '0);
        send_op(OP_DELETE, KEY_MAX, '1);
        send_op(OP_UNUSED, '0, '0);
        send_op(OP_INSERT, '0, '0);
        send_op(OP_INSERT, KEY_MAX, '1);
        send_op(OP_SEARCH, '0, '1);
        send_op(OP_SEARCH, KEY_MAX, '0);
        send_op(OP_INSERT, 31'd16, 32'h1111_1111);
        send_op(OP_INSERT, 31'd32, 32'h2222_2222);
        send_op(OP_INSERT, 31'd16, 32'h3333_3333);
        send_op(OP_SEARCH, 31'd16, '0);
        send_op(OP_DELETE, 31'd16, '0);
        send_op(OP_SEARCH, 31'd16, '0);
        send_op(OP_DELETE, 31'd16, '0);
        send_op(OP_SEARCH, 31'd16, '0);
        send_op(OP_DELETE, '0, '0);
        send_op(OP_SEARCH, 31'd32, '0);
        send_op(OP_INSERT, 31'd48, 32'h4444_4444);
        send_op(OP_SEARCH, 31'd48, '0);
        send_op(OP_DELETE, 31'd64, '0);
        send_op(OP_UNUSED, 31'd32, '1);
        send_op(OP_SEARCH, 31'd32, '0);
        send_op(OP_SEARCH, KEY_MAX, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0)
                tx_quiet = ($urandom_range(0, 2) == 0);
            send_op(pick_op(), pick_key(), pick_value());
        end
        s_axis_tvalid = 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d operations: %0d search hits, %0d misses, %0d pool-full beats.",
                 n_sent, sb.n_found, sb.n_miss, sb.n_full);
        $display("Pool nodes handed out: %0d of %0d; mismatches: %0d.",
                 sb.next_free, POOL, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
